@@ src/vqda_pkg.sv @@
// Shared types, codes and constants for the virtqueue descriptor allocator.
// No dependencies; every other file imports this package.
package vqda_pkg;

  // Default descriptor table size
  localparam int QUEUE_SIZE_DEF = 8;

  // Fixed field widths of the stream payload
  localparam int HEAD_W      = 4;
  localparam int INDEX_OUT_W = 3;
  localparam int COUNT_OUT_W = 4;

  // Result status codes
  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_NOSPACE = 2'd1,
    ST_RANGE   = 2'd2,
    ST_FREED   = 2'd3
  } status_t;

  // Descriptor flag bits as reported in data_flags
  localparam logic [1:0] FLAG_NEXT  = 2'b01;
  localparam logic [1:0] FLAG_WRITE = 2'b10;

  // Command codes on the input tuser
  localparam logic CMD_SUBMIT = 1'b0;
  localparam logic CMD_FREE   = 1'b1;

  // Job kinds decided by the front end
  typedef enum logic [1:0] {
    KIND_SUBMIT   = 2'd0,
    KIND_FREE     = 2'd1,
    KIND_BAD_HEAD = 2'd2
  } kind_t;

  // One classified job as held in the queue
  typedef struct packed {
    kind_t             kind;
    logic              write_request;
    logic [63:0]       sector;
    logic [15:0]       data_length;
    logic [HEAD_W-1:0] chain_head;
  } job_t;

  // One result item
  typedef struct packed {
    status_t                status;
    logic [INDEX_OUT_W-1:0] head_index;
    logic [INDEX_OUT_W-1:0] data_index;
    logic [INDEX_OUT_W-1:0] status_index;
    logic [1:0]             data_flags;
    logic [INDEX_OUT_W-1:0] avail_slot;
    logic                   request_type;
    logic [63:0]            request_sector;
    logic [15:0]            request_length;
    logic [COUNT_OUT_W-1:0] freed_count;
  } result_t;

endpackage

@@ src/vqda_front.sv @@
// Front end: takes input beats, classifies them and pushes jobs to the queue.
// Depends on vqda_pkg.
module vqda_front #(
  parameter int QUEUE_SIZE = vqda_pkg::QUEUE_SIZE_DEF
) (
  input  logic                      in_valid,
  output logic                      in_ready,
  input  logic                      cmd,
  input  logic                      write_request,
  input  logic [63:0]               sector,
  input  logic [15:0]               data_length,
  input  logic [vqda_pkg::HEAD_W-1:0] chain_head,
  input  logic                      full,
  output logic                      push,
  output vqda_pkg::job_t            job
);
  import vqda_pkg::*;

  logic head_bad;

  // A chain head past the table end needs no work in the back end
  assign head_bad = (32'(chain_head) >= QUEUE_SIZE);

  assign in_ready = !full;
  assign push     = in_valid && !full;

  // Classify the beat
  always_comb begin
    job.write_request = write_request;
    job.sector        = sector;
    job.data_length   = data_length;
    job.chain_head    = chain_head;
    if (cmd == CMD_SUBMIT) begin
      job.kind = KIND_SUBMIT;
    end else if (head_bad) begin
      job.kind = KIND_BAD_HEAD;
    end else begin
      job.kind = KIND_FREE;
    end
  end

endmodule

@@ src/vqda_fifo.sv @@
// Two-entry job queue between front and back end.
// Depends on vqda_pkg.
module vqda_fifo (
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  input  vqda_pkg::job_t push_job,
  output logic           full,
  input  logic           pop,
  output vqda_pkg::job_t pop_job,
  output logic           empty
);
  import vqda_pkg::*;

  job_t       slots [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] fill;

  assign full    = (fill == 2'd2);
  assign empty   = (fill == 2'd0);
  assign pop_job = slots[rd_ptr];

  // Pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      fill   <= 2'd0;
    end else begin
      if (push) wr_ptr <= !wr_ptr;
      if (pop)  rd_ptr <= !rd_ptr;
      if (push && !pop) begin
        fill <= fill + 2'd1;
      end else if (pop && !push) begin
        fill <= fill - 2'd1;
      end
    end
  end

  // Entry storage
  always_ff @(posedge clk) begin
    if (push) slots[wr_ptr] <= push_job;
  end

endmodule

@@ src/vqda_back.sv @@
// Back end: descriptor table, submit allocation, chain free walk, result register.
// Depends on vqda_pkg.
module vqda_back #(
  parameter int QUEUE_SIZE = vqda_pkg::QUEUE_SIZE_DEF
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              empty,
  input  vqda_pkg::job_t    job,
  output logic              pop,
  output logic              out_valid,
  input  logic              out_ready,
  output vqda_pkg::result_t out_res
);
  import vqda_pkg::*;

  localparam int IDX_W = $clog2(QUEUE_SIZE);
  localparam int CNT_W = $clog2(QUEUE_SIZE + 1);

  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,
    S_PICK = 5'b00010,
    S_WALK = 5'b00100,
    S_LINK = 5'b01000,
    S_DONE = 5'b10000
  } state_t;

  state_t                state;
  logic [QUEUE_SIZE-1:0] free_map;
  logic [QUEUE_SIZE-1:0] has_next;
  logic [QUEUE_SIZE-1:0] device_writes;
  logic [QUEUE_SIZE-1:0] pick_mask;
  logic [IDX_W-1:0]      pick0;
  logic [IDX_W-1:0]      pick1;
  logic [1:0]            pick_cnt;
  logic [IDX_W-1:0]      cur;
  logic [IDX_W-1:0]      link_q;
  logic [CNT_W-1:0]      count;
  logic [15:0]           avail_index;
  logic [IDX_W-1:0]      avail_pos;
  job_t                  job_q;
  result_t               done_res;

  logic [IDX_W-1:0] next_link  [QUEUE_SIZE];
  logic [IDX_W-1:0] avail_ring [QUEUE_SIZE];

  logic             found;
  logic [IDX_W-1:0] ff_idx;
  logic             commit;
  logic             link_we;
  logic [IDX_W-1:0] link_waddr;
  logic             load;

  // Lowest set bit of a mask
  function automatic logic [IDX_W:0] find_first(input logic [QUEUE_SIZE-1:0] m);
    logic [IDX_W:0] r;
    r = '0;
    for (int i = QUEUE_SIZE - 1; i >= 0; i--) begin
      if (m[i]) r = {1'b1, IDX_W'(i)};
    end
    return r;
  endfunction

  assign {found, ff_idx} = find_first(pick_mask);
  assign commit     = (state == S_PICK) && found && (pick_cnt == 2'd2);
  assign link_we    = (state == S_PICK) && found && (pick_cnt != 2'd0);
  assign link_waddr = (pick_cnt == 2'd1) ? pick0 : pick1;
  assign pop        = (state == S_IDLE) && !empty;
  assign load       = (state == S_DONE) && (!out_valid || out_ready);

  // Link and avail ring memories
  always_ff @(posedge clk) begin
    if (link_we) next_link[link_waddr] <= ff_idx;
    if (commit)  avail_ring[avail_pos] <= pick0;
    link_q <= next_link[cur];
  end

  // Sequencer and descriptor state
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      free_map      <= '1;
      has_next      <= '0;
      device_writes <= '0;
      avail_index   <= '0;
      avail_pos     <= '0;
      out_valid     <= 1'b0;
    end else begin
      if (out_valid && out_ready && !load) out_valid <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (!empty) begin
            job_q <= job;
            case (job.kind)
              KIND_SUBMIT: begin
                done_res  <= '0;
                pick_mask <= free_map;
                pick_cnt  <= 2'd0;
                state     <= S_PICK;
              end
              KIND_FREE: begin
                done_res <= '0;
                cur      <= IDX_W'(job.chain_head);
                count    <= '0;
                state    <= S_WALK;
              end
              default: begin
                done_res <= '{status: ST_RANGE, default: '0};
                state    <= S_DONE;
              end
            endcase
          end
        end
        S_PICK: begin
          if (!found) begin
            done_res.status <= ST_NOSPACE;
            state           <= S_DONE;
          end else begin
            pick_mask[ff_idx] <= 1'b0;
            if (pick_cnt == 2'd0) pick0 <= ff_idx;
            if (pick_cnt == 2'd1) pick1 <= ff_idx;
            pick_cnt <= pick_cnt + 2'd1;
            if (pick_cnt == 2'd2) begin
              // Claim and link header, data and status descriptors
              free_map[pick0]      <= 1'b0;
              free_map[pick1]      <= 1'b0;
              free_map[ff_idx]     <= 1'b0;
              has_next[pick0]      <= 1'b1;
              has_next[pick1]      <= 1'b1;
              has_next[ff_idx]     <= 1'b0;
              device_writes[pick0] <= 1'b0;
              device_writes[pick1] <= !job_q.write_request;
              device_writes[ff_idx] <= 1'b1;
              avail_index <= avail_index + 16'd1;
              if (avail_index == 16'hffff || avail_pos == IDX_W'(QUEUE_SIZE - 1)) begin
                avail_pos <= '0;
              end else begin
                avail_pos <= avail_pos + IDX_W'(1);
              end
              done_res.status         <= ST_OK;
              done_res.head_index     <= INDEX_OUT_W'(pick0);
              done_res.data_index     <= INDEX_OUT_W'(pick1);
              done_res.status_index   <= INDEX_OUT_W'(ff_idx);
              done_res.data_flags     <= FLAG_NEXT | (job_q.write_request ? 2'b00 : FLAG_WRITE);
              done_res.avail_slot     <= INDEX_OUT_W'(avail_pos);
              done_res.request_type   <= job_q.write_request;
              done_res.request_sector <= job_q.sector;
              done_res.request_length <= job_q.data_length;
              state                   <= S_DONE;
            end
          end
        end
        S_WALK: begin
          if (free_map[cur]) begin
            done_res.status      <= ST_FREED;
            done_res.freed_count <= COUNT_OUT_W'(count);
            state                <= S_DONE;
          end else begin
            // Release this descriptor; its link is read this cycle
            free_map[cur]      <= 1'b1;
            has_next[cur]      <= 1'b0;
            device_writes[cur] <= 1'b0;
            count              <= count + CNT_W'(1);
            if (!has_next[cur]) begin
              done_res.status      <= ST_OK;
              done_res.freed_count <= COUNT_OUT_W'(count + CNT_W'(1));
              state                <= S_DONE;
            end else begin
              state <= S_LINK;
            end
          end
        end
        S_LINK: begin
          cur   <= link_q;
          state <= S_WALK;
        end
        S_DONE: begin
          if (load) begin
            out_res   <= done_res;
            out_valid <= 1'b1;
            state     <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // Checks
  a_picks_distinct: assert property (@(posedge clk) disable iff (rst)
    commit |-> (pick0 != pick1) && (pick1 != ff_idx) && (pick0 != ff_idx))
    else $error("submit picked one descriptor twice");
  a_commit_claims: assert property (@(posedge clk) disable iff (rst)
    commit |=> !free_map[pick0] && !free_map[pick1])
    else $error("claimed descriptors still marked free");
  a_walk_in_range: assert property (@(posedge clk) disable iff (rst)
    (state == S_WALK) |-> (32'(cur) < QUEUE_SIZE) && (32'(count) <= QUEUE_SIZE))
    else $error("free walk left the table");
  a_result_loaded: assert property (@(posedge clk) disable iff (rst)
    load |=> out_valid && (state == S_IDLE))
    else $error("finished result not presented");

endmodule

@@ src/virtqueue_descriptor_allocator.sv @@
// Virtqueue descriptor allocator top level: front end, job queue, back end.
// A submit passes through the back end as pop, three picks of the lowest free
// descriptor and result load; a free visits each descriptor of the chain and reads
// the link of each but the last. The back end takes one job at a time from the queue.
// Reset clears the descriptor table, avail index and queue; no sweep.
// Depends on vqda_pkg, vqda_front, vqda_fifo, vqda_back.
module virtqueue_descriptor_allocator #(
  parameter int QUEUE_SIZE = vqda_pkg::QUEUE_SIZE_DEF
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // tdata: write_request[0], sector[64:1], data_length[80:65], chain_head[84:81], zeros
  input  logic [87:0]  s_axis_tdata,
  // tuser: cmd[0]
  input  logic         s_axis_tuser,
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // tdata: head_index[2:0], data_index[5:3], status_index[8:6], data_flags[10:9],
  //        avail_slot[13:11], request_type[14], request_sector[78:15],
  //        request_length[94:79], freed_count[98:95], zeros
  output logic [103:0] m_axis_tdata,
  // tuser: status[1:0]
  output logic [1:0]   m_axis_tuser
);
  import vqda_pkg::*;

  logic    push;
  logic    pop;
  logic    full;
  logic    empty;
  job_t    push_job;
  job_t    pop_job;
  result_t res;

  vqda_front #(.QUEUE_SIZE(QUEUE_SIZE)) u_front (
    .in_valid      (s_axis_tvalid),
    .in_ready      (s_axis_tready),
    .cmd           (s_axis_tuser),
    .write_request (s_axis_tdata[0]),
    .sector        (s_axis_tdata[64:1]),
    .data_length   (s_axis_tdata[80:65]),
    .chain_head    (s_axis_tdata[84:81]),
    .full          (full),
    .push          (push),
    .job           (push_job)
  );

  vqda_fifo u_fifo (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_job (push_job),
    .full     (full),
    .pop      (pop),
    .pop_job  (pop_job),
    .empty    (empty)
  );

  vqda_back #(.QUEUE_SIZE(QUEUE_SIZE)) u_back (
    .clk       (clk),
    .rst       (rst),
    .empty     (empty),
    .job       (pop_job),
    .pop       (pop),
    .out_valid (m_axis_tvalid),
    .out_ready (m_axis_tready),
    .out_res   (res)
  );

  // Output packing
  assign m_axis_tuser = res.status;
  assign m_axis_tdata = {5'd0, res.freed_count, res.request_length, res.request_sector,
                         res.request_type, res.avail_slot, res.data_flags,
                         res.status_index, res.data_index, res.head_index};

endmodule
